### sv/gcd_pkg.sv
// Shared constants, types and the arctangent table for the great-circle distance block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package gcd_pkg;

  localparam int FRACTION_BITS = 20;
  localparam int CORDIC_STEPS  = 24;

  // Width of a radian angle (Q30) or a difference of two of them.
  localparam int ANG_W = 64 - FRACTION_BITS;
  // Width of CORDIC datapaths, sines, cosines and products.
  localparam int CW    = 34;
  localparam int OUT_W = 28;
  localparam int RES_W = FRACTION_BITS + 10;

  localparam logic [63:0] PI_Q30          = 64'hC90FDAA2;
  localparam logic [63:0] TWO_PI_Q30      = 2 * PI_Q30;
  localparam logic [63:0] HALF_PI_Q30     = PI_Q30 / 2;
  localparam logic [63:0] DEG_TO_RAD_Q36  = 64'h3243F6A888 / 64'd180;
  localparam logic [63:0] RAD2_TO_DEG_Q24 = (64'd360 << 54) / PI_Q30;
  localparam logic [63:0] CORDIC_GAIN_INV = 64'h26DD3B6A;
  localparam logic [63:0] Q30_ONE         = 64'd1 << 30;

  // Angle reduction: an offset of 2*pi times a power of two, plus pi, makes the angle
  // non-negative, then one compare and subtract per stage removes multiples.
  localparam int RED_K = ANG_W - 33;
  localparam int RED_N = RED_K + 2;
  localparam int U_W   = ANG_W + 2;
  localparam logic [63:0] RED_OFS = (TWO_PI_Q30 << RED_K) + PI_Q30;

  localparam int SQ_W     = 62;
  localparam int SQ_STEPS = 31;

  localparam int LANE_LAT = RED_N + CORDIC_STEPS + 2;
  localparam int SQRT_LAT = SQ_STEPS + 1;
  localparam int PIPE_LAT = 2 + LANE_LAT + 3 + SQRT_LAT + (CORDIC_STEPS + 1) + 2;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [CW-1:0]    cw_t;
  typedef logic [30:0]             q30u_t;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  function automatic cw_t atan_q30(input int idx);
    return cw_t'({2'b00, ATAN_Q30[idx]});
  endfunction

endpackage
`default_nettype wire

### sv/gcd_rot_lane.sv
// One rotation lane: reduction of an angle into [-pi, pi), optional halving,
// fold into [-pi/2, pi/2] and a pipelined CORDIC giving sine and cosine. Uses gcd_pkg.
`default_nettype none
module gcd_rot_lane (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          half,
  input  wire gcd_pkg::ang_t ang,
  output gcd_pkg::cw_t       sin_o,
  output gcd_pkg::cw_t       cos_o
);

  localparam int N = gcd_pkg::CORDIC_STEPS;
  localparam gcd_pkg::cw_t PI_C   = gcd_pkg::cw_t'(gcd_pkg::PI_Q30[gcd_pkg::CW-1:0]);
  localparam gcd_pkg::cw_t HALF_C = gcd_pkg::cw_t'(gcd_pkg::HALF_PI_Q30[gcd_pkg::CW-1:0]);

  logic [gcd_pkg::U_W-1:0] u_r [gcd_pkg::RED_N+1];
  gcd_pkg::cw_t x_r [N+1];
  gcd_pkg::cw_t y_r [N+1];
  gcd_pkg::cw_t z_r [N+1];
  logic         flip_r [N+1];

  gcd_pkg::cw_t m_c, zh_c, zf_c;
  logic         flip_c;

  always_comb begin
    m_c  = gcd_pkg::cw_t'({1'b0, u_r[gcd_pkg::RED_N][gcd_pkg::CW-2:0]}) - PI_C;
    zh_c = half ? (m_c >>> 1) : m_c;
    if (zh_c > HALF_C) begin
      zf_c   = zh_c - PI_C;
      flip_c = 1'b1;
    end else if (zh_c < -HALF_C) begin
      zf_c   = zh_c + PI_C;
      flip_c = 1'b1;
    end else begin
      zf_c   = zh_c;
      flip_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= {{(gcd_pkg::U_W-gcd_pkg::ANG_W){ang[gcd_pkg::ANG_W-1]}}, ang}
                + gcd_pkg::RED_OFS[gcd_pkg::U_W-1:0];
      for (int k = 0; k < gcd_pkg::RED_N; k++) begin
        if (u_r[k] >= (gcd_pkg::U_W'(gcd_pkg::TWO_PI_Q30) << (gcd_pkg::RED_N-1-k))) begin
          u_r[k+1] <= u_r[k] - (gcd_pkg::U_W'(gcd_pkg::TWO_PI_Q30) << (gcd_pkg::RED_N-1-k));
        end else begin
          u_r[k+1] <= u_r[k];
        end
      end
      x_r[0]    <= gcd_pkg::cw_t'(gcd_pkg::CORDIC_GAIN_INV[gcd_pkg::CW-1:0]);
      y_r[0]    <= '0;
      z_r[0]    <= zf_c;
      flip_r[0] <= flip_c;
      for (int i = 0; i < N; i++) begin
        if (!z_r[i][gcd_pkg::CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - gcd_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + gcd_pkg::atan_q30(i);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  assign sin_o = flip_r[N] ? -y_r[N] : y_r[N];
  assign cos_o = flip_r[N] ? -x_r[N] : x_r[N];

endmodule
`default_nettype wire

### sv/gcd_sqrt.sv
// Pipelined digit-by-digit square roots of a*2^30 and (1-a)*2^30, one result
// bit per stage for both roots side by side. Uses gcd_pkg.
`default_nettype none
module gcd_sqrt (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire gcd_pkg::q30u_t a_i,
  output gcd_pkg::q30u_t      ys_o,
  output gcd_pkg::q30u_t      xs_o
);

  localparam int S = gcd_pkg::SQ_STEPS;
  localparam int W = gcd_pkg::SQ_W;

  logic [W-1:0] rem_r [S+1][2];
  logic [W-1:0] res_r [S+1][2];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0][0] <= {1'b0, a_i, 30'd0};
      rem_r[0][1] <= {1'b0, 31'(gcd_pkg::Q30_ONE) - a_i, 30'd0};
      res_r[0][0] <= '0;
      res_r[0][1] <= '0;
      for (int j = 0; j < S; j++) begin
        for (int l = 0; l < 2; l++) begin
          if (rem_r[j][l] >= res_r[j][l] + (W'(1) << (60 - 2*j))) begin
            rem_r[j+1][l] <= rem_r[j][l] - (res_r[j][l] + (W'(1) << (60 - 2*j)));
            res_r[j+1][l] <= (res_r[j][l] >> 1) + (W'(1) << (60 - 2*j));
          end else begin
            rem_r[j+1][l] <= rem_r[j][l];
            res_r[j+1][l] <= res_r[j][l] >> 1;
          end
        end
      end
    end
  end

  assign ys_o = res_r[S][0][30:0];
  assign xs_o = res_r[S][1][30:0];

endmodule
`default_nettype wire

### sv/great_circle_distance.sv
// Great-circle distance by the haversine formula, fully pipelined.
// Accepts one word per cycle whenever the output register is empty or its word is taken.
// The pipeline depth is set by the angle reduction, two CORDIC chains and the 31-step square root.
// Reset (rst_n low, synchronous) empties the pipeline; payload registers are not reset.
`default_nettype none
module great_circle_distance (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // fields from bit 0: first_horizontal[31:0], first_vertical[63:32],
  // second_horizontal[95:64], second_vertical[127:96]
  input  wire logic [127:0] in_tdata,
  // fields from bit 0: in_radians
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fields from bit 0: separation_degrees[27:0], zero padding [31:28]
  output logic [31:0]       out_tdata
);

  localparam int N  = gcd_pkg::CORDIC_STEPS;
  localparam int FB = gcd_pkg::FRACTION_BITS;
  localparam int CW = gcd_pkg::CW;
  localparam logic [gcd_pkg::RES_W-1:0] TOP_DEG = gcd_pkg::RES_W'(180) << FB;
  localparam logic [gcd_pkg::RES_W-1:0] OUT_MAX = gcd_pkg::RES_W'({gcd_pkg::OUT_W{1'b1}});

  // The whole pipeline moves as one: it advances whenever the output register
  // is empty or its word is being taken. Valid bits ride alongside the data.
  logic en;
  logic vld_r [gcd_pkg::PIPE_LAT];

  assign en        = !vld_r[gcd_pkg::PIPE_LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < gcd_pkg::PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < gcd_pkg::PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Degrees are scaled by pi/180 in Q36 with a floored shift; radians are
  // simply moved up to Q30. The pi/180 constant fits in 31 bits.
  function automatic gcd_pkg::ang_t to_rad(input logic signed [31:0] v, input logic rad);
    logic signed [63:0] p;
    p = v * $signed({1'b0, gcd_pkg::DEG_TO_RAD_Q36[30:0]});
    if (rad) begin
      return gcd_pkg::ang_t'(v) <<< (30 - FB);
    end
    return gcd_pkg::ang_t'(p >>> (FB + 6));
  endfunction

  // Stage 1: input register.
  logic [127:0] raw_r;
  logic         rad_r;
  // Stage 2: radians.
  gcd_pkg::ang_t h1_r, v1_r, h2_r, v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r <= in_tdata;
      rad_r <= in_tuser;
      h1_r  <= to_rad(raw_r[31:0], rad_r);
      v1_r  <= to_rad(raw_r[63:32], rad_r);
      h2_r  <= to_rad(raw_r[95:64], rad_r);
      v2_r  <= to_rad(raw_r[127:96], rad_r);
    end
  end

  // Four rotation lanes: half differences for the sines, the two vertical
  // angles for the cosines.
  gcd_pkg::cw_t sv, sh, c1, c2;
  gcd_pkg::cw_t sv_cos_nc, sh_cos_nc, c1_sin_nc, c2_sin_nc;

  gcd_rot_lane u_lane_dv (.clk(clk), .en(en), .half(1'b1), .ang(v2_r - v1_r),
                          .sin_o(sv), .cos_o(sv_cos_nc));
  gcd_rot_lane u_lane_dh (.clk(clk), .en(en), .half(1'b1), .ang(h2_r - h1_r),
                          .sin_o(sh), .cos_o(sh_cos_nc));
  gcd_rot_lane u_lane_v1 (.clk(clk), .en(en), .half(1'b0), .ang(v1_r),
                          .sin_o(c1_sin_nc), .cos_o(c1));
  gcd_rot_lane u_lane_v2 (.clk(clk), .en(en), .half(1'b0), .ang(v2_r),
                          .sin_o(c2_sin_nc), .cos_o(c2));

  // Haversine term over three stages: squares and the cosine product, the
  // second product, then the sum clamped into [0, 1].
  logic signed [2*CW-1:0] mul_sv, mul_sh, mul_c, mul_q;
  gcd_pkg::cw_t p_sv_r, p_sh_r, p_c_r, p_sv2_r, q_r;
  logic signed [CW:0] sum_c;
  gcd_pkg::q30u_t a_r;

  assign mul_sv = sv * sv;
  assign mul_sh = sh * sh;
  assign mul_c  = c1 * c2;
  assign mul_q  = p_c_r * p_sh_r;
  assign sum_c  = {p_sv2_r[CW-1], p_sv2_r} + {q_r[CW-1], q_r};

  always_ff @(posedge clk) begin
    if (en) begin
      p_sv_r  <= mul_sv[30 +: CW];
      p_sh_r  <= mul_sh[30 +: CW];
      p_c_r   <= mul_c[30 +: CW];
      q_r     <= mul_q[30 +: CW];
      p_sv2_r <= p_sv_r;
      if (sum_c[CW]) begin
        a_r <= '0;
      end else if (sum_c > (CW+1)'(gcd_pkg::Q30_ONE)) begin
        a_r <= 31'(gcd_pkg::Q30_ONE);
      end else begin
        a_r <= sum_c[30:0];
      end
    end
  end

  gcd_pkg::q30u_t ys, xs;

  gcd_sqrt u_sqrt (.clk(clk), .en(en), .a_i(a_r), .ys_o(ys), .xs_o(xs));

  // Vectoring CORDIC: atan2(ys, xs), which is half the separation in radians,
  // so the output constant carries the factor of two.
  gcd_pkg::cw_t vx_r [N+1];
  gcd_pkg::cw_t vy_r [N+1];
  gcd_pkg::cw_t vz_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= gcd_pkg::cw_t'({3'b000, xs});
      vy_r[0] <= gcd_pkg::cw_t'({3'b000, ys});
      vz_r[0] <= '0;
      for (int i = 0; i < N; i++) begin
        if (!vy_r[i][CW-1]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + gcd_pkg::atan_q30(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - gcd_pkg::atan_q30(i);
        end
      end
    end
  end

  // Output scaling: a negative residue counts as zero, the product is rounded
  // half up, clamped at 180 degrees and then at the field width.
  logic [31:0] zc;
  logic [62:0] prod_r;
  logic [63:0] rnd_c;
  logic [gcd_pkg::RES_W-1:0] res_c, lim_c;
  logic [gcd_pkg::OUT_W-1:0] out_data_r;

  assign zc    = vz_r[N][CW-1] ? 32'd0 : vz_r[N][31:0];
  assign rnd_c = {1'b0, prod_r} + (64'd1 << (53 - FB));
  assign res_c = rnd_c[63 -: gcd_pkg::RES_W];

  always_comb begin
    lim_c = (res_c > TOP_DEG) ? TOP_DEG : res_c;
    if (lim_c > OUT_MAX) lim_c = OUT_MAX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= zc * gcd_pkg::RAD2_TO_DEG_Q24[30:0];
      out_data_r <= lim_c[gcd_pkg::OUT_W-1:0];
    end
  end

  assign out_tvalid = vld_r[gcd_pkg::PIPE_LAT-1];
  assign out_tdata  = {4'd0, out_data_r};

endmodule
`default_nettype wire

### sv/gcd_checker.sv
// Port-level checks for great_circle_distance and the bind that attaches them.
// Uses gcd_pkg for the output limit.
`default_nettype none
module gcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  localparam logic [31:0] TOP_DEG = 32'(180) << gcd_pkg::FRACTION_BITS;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  // With no result waiting, the block always takes new words.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused with an empty output register");

  // Every separation lies within 0 to 180 degrees and the padding is zero.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= TOP_DEG) && (out_tdata[31:28] == 4'd0))
    else $error("separation outside 0 to 180 degrees");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present after reset");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
`default_nettype wire
